[hdl/sorted_set_engine_assert.svh]
// Assertion helpers for the sorted set engine.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef SORTED_SET_ENGINE_ASSERT_SVH
`define SORTED_SET_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define SSE_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sse_pkg.sv]
`timescale 1ns / 1ps

package sse_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        ACT_CLEAR    = 2'd0,
        ACT_ADD      = 2'd1,
        ACT_REMOVE   = 2'd2,
        ACT_CONTAINS = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_INSERT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] count;
        logic               full_reject;
    } result_t;

endpackage

[hdl/sorted_set_engine.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  action, value
// out      output     out_valid/out_stall  hit, count, full_reject
//
// One transaction at a time: clear and a rejected negative add go straight to the finish
// state, a search does one read and one compare per probe, and an insert or remove then
// moves the m entries above the found position one slot at a time.
// Reset empties the set at once; the entry memory is never cleared.
// A stalled result waits in the output register while the next transaction runs.
module sorted_set_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        action,
    input  logic signed [sse_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic [sse_pkg::COUNT_W-1:0]       count,
    output logic                              full_reject
);
    import sse_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic                     res_ready;
    logic                     res_done;
    result_t                  res;
    result_t                  out_reg;
    logic                     out_valid_reg;

    sse_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sse_seq #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .res_ready (res_ready),
        .res_done  (res_done),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_done)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_reg.hit;
    assign count       = out_reg.count;
    assign full_reject = out_reg.full_reject;

endmodule

[hdl/sse_mem.sv]
`timescale 1ns / 1ps

module sse_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 wr_addr,
    input  logic signed [sse_pkg::DATA_W-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [ADDR_W-1:0]                 rd_addr,
    output logic signed [sse_pkg::DATA_W-1:0] rd_data
);
    import sse_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/sse_seq.sv]
`timescale 1ns / 1ps

module sse_seq #(
    parameter int CAPACITY = 64,
    parameter int ADDR_W   = 6,
    parameter int CNT_W    = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        action,
    input  logic signed [sse_pkg::DATA_W-1:0] value,
    input  logic                              res_ready,
    output logic                              res_done,
    output sse_pkg::result_t                  res,
    output logic                              wr_en,
    output logic [ADDR_W-1:0]                 wr_addr,
    output logic signed [sse_pkg::DATA_W-1:0] wr_data,
    output logic                              rd_en,
    output logic [ADDR_W-1:0]                 rd_addr,
    input  logic signed [sse_pkg::DATA_W-1:0] rd_data
);
    import sse_pkg::*;

    state_t                   state_reg, state_next;
    action_t                  act_reg, act_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]         used_reg, used_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         src_reg, src_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic [ADDR_W-1:0]        wa_reg, wa_next;
    logic                     pend_reg, pend_next;
    logic                     hit_reg, hit_next;
    logic                     full_reg, full_next;

    logic [CNT_W-1:0] mid;
    logic             range_open;
    logic             is_full;
    logic             probe_lt;
    logic             probe_eq;
    logic             in_accept;
    logic             shift_done;
    action_t          in_act;

    assign in_act     = action_t'(action);
    assign in_accept  = in_valid && !in_stall;
    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign range_open = lo_reg < hi_reg;
    assign is_full    = used_reg >= CNT_W'(CAPACITY);
    // The one shared comparator: probed entry against the operand.
    assign probe_lt   = rd_data < val_reg;
    assign probe_eq   = rd_data == val_reg;
    assign shift_done = (rem_reg == '0) && !pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        val_reg  <= val_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        pos_reg  <= pos_next;
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        wa_reg   <= wa_next;
        hit_reg  <= hit_next;
        full_reg <= full_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_act == ACT_CLEAR || (in_act == ACT_ADD && value[DATA_W-1]))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (range_open)
                begin
                    state_next = S_CMP;
                end
                else if (act_reg == ACT_ADD && !is_full)
                begin
                    state_next = S_SHIFT_UP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_CMP:
            begin
                if (!probe_eq)
                begin
                    state_next = S_PROBE;
                end
                else if (act_reg == ACT_REMOVE)
                begin
                    state_next = S_SHIFT_DN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_UP:
            begin
                if (shift_done)
                begin
                    state_next = S_INSERT;
                end
            end
            S_SHIFT_DN:
            begin
                if (shift_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_INSERT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and memory port control.
    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
        res_done = (state_reg == S_FINISH) && res_ready;
        rd_en    = 1'b0;
        rd_addr  = src_reg[ADDR_W-1:0];
        wr_en    = 1'b0;
        wr_addr  = wa_reg;
        wr_data  = rd_data;
        unique case (state_reg)
            S_PROBE:
            begin
                rd_en   = range_open;
                rd_addr = mid[ADDR_W-1:0];
            end
            S_SHIFT_UP, S_SHIFT_DN:
            begin
                rd_en = (rem_reg != '0);
                wr_en = pend_reg;
            end
            S_INSERT:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[ADDR_W-1:0];
                wr_data = val_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign res.hit         = hit_reg;
    assign res.count       = COUNT_W'(used_reg);
    assign res.full_reject = full_reg;

    // Datapath registers.
    always_comb
    begin
        act_next  = act_reg;
        val_next  = val_reg;
        used_next = used_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        pos_next  = pos_reg;
        src_next  = src_reg;
        rem_next  = rem_reg;
        wa_next   = wa_reg;
        pend_next = pend_reg;
        hit_next  = hit_reg;
        full_next = full_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    act_next  = in_act;
                    val_next  = value;
                    lo_next   = '0;
                    hi_next   = used_reg;
                    hit_next  = 1'b0;
                    full_next = 1'b0;
                    pend_next = 1'b0;
                    if (in_act == ACT_CLEAR)
                    begin
                        used_next = '0;
                    end
                end
            end
            S_PROBE:
            begin
                if (!range_open)
                begin
                    // Not present: lo is the insertion point.
                    pos_next = lo_reg;
                    if (act_reg == ACT_ADD)
                    begin
                        full_next = is_full;
                        src_next  = used_reg - 1'b1;
                        rem_next  = used_reg - lo_reg;
                    end
                end
            end
            S_CMP:
            begin
                if (probe_eq)
                begin
                    hit_next = (act_reg != ACT_ADD);
                    src_next = mid + 1'b1;
                    rem_next = used_reg - mid - 1'b1;
                end
                else if (probe_lt)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
            end
            S_SHIFT_UP:
            begin
                // Read one entry per cycle and write it one slot higher the next cycle.
                if (rem_reg != '0)
                begin
                    wa_next   = src_reg[ADDR_W-1:0] + 1'b1;
                    src_next  = src_reg - 1'b1;
                    rem_next  = rem_reg - 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_SHIFT_DN:
            begin
                if (rem_reg != '0)
                begin
                    wa_next   = src_reg[ADDR_W-1:0] - 1'b1;
                    src_next  = src_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        used_next = used_reg - 1'b1;
                    end
                end
            end
            S_INSERT:
            begin
                used_next = used_reg + 1'b1;
                hit_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    `include "sorted_set_engine_assert.svh"

    `SSE_ASSERT_IMPL(a_used_bound, 1'b1, used_reg <= CNT_W'(CAPACITY), "count above capacity")
    `SSE_ASSERT_NEXT(a_accept_busy, in_accept, state_reg != S_IDLE, "idle after transaction")
    `SSE_ASSERT_IMPL(a_cmp_after_probe, state_reg == S_CMP, $past(state_reg) == S_PROBE, "compare without read")
    `SSE_ASSERT_IMPL(a_hit_full_excl, res_done, !(res.hit && res.full_reject), "hit with full reject")

endmodule
